// ===== rtl/skl_pkg.sv =====
// Package for the sorted key list: sizes, request and result types, cell control.
package skl_pkg;

  localparam int LIST_DEPTH = 32;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int KEY_W      = 16;
  localparam int PAY_W      = 16;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic             req_type;
    logic [KEY_W-1:0] entry_key;
    logic [PAY_W-1:0] entry_payload;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [5:0]       entry_count;
    logic [PAY_W-1:0] removed_payload;
  } res_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic rm;
  } op_t;

endpackage

// ===== rtl/sorted_key_list.sv =====
// Sorted key list top level: row of cells, fill count and result register.
// Latency: a result is valid in the cycle after its request is accepted.
// Throughput: one request per cycle while results are taken; every cell compares
// and shifts in that one cycle, and the input stalls only while a result is held.
// Reset clears the fill count and result valid; cell contents are not cleared
// and no clearing pass is run, so requests are taken straight after reset.
module sorted_key_list (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  skl_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_stall,
  output skl_pkg::res_t res
);

  localparam int N = skl_pkg::LIST_DEPTH;

  logic [skl_pkg::CNT_W-1:0] count;
  logic [skl_pkg::CNT_W-1:0] count_next;
  logic                      accept;
  logic                      full;
  logic                      found;
  logic [N-1:0]              valid;
  logic [N-1:0]              lt;
  logic [N-1:0]              hit;
  logic [N:0]                prev_lt;
  skl_pkg::entry_t           entry [N];
  skl_pkg::entry_t           bcast;
  skl_pkg::op_t              op;
  logic [skl_pkg::PAY_W-1:0] hit_payload;
  skl_pkg::res_t             res_next;

  assign req_stall = res_valid && res_stall;
  assign accept    = req_valid && !req_stall;
  assign full      = (count == skl_pkg::CNT_W'(N));
  assign found     = |hit;

  assign bcast.key     = req.entry_key;
  assign bcast.payload = req.entry_payload;

  assign op.ins = accept && (req.req_type == skl_pkg::REQ_INSERT) && !full;
  assign op.rm  = accept && (req.req_type == skl_pkg::REQ_REMOVE) && found;

  assign prev_lt[0] = 1'b1;

  for (genvar i = 0; i < N; i++) begin : g_cell
    skl_pkg::entry_t prev_e;
    skl_pkg::entry_t next_e;

    assign valid[i]     = (skl_pkg::CNT_W'(i) < count);
    assign prev_lt[i+1] = lt[i];

    if (i == 0) begin : g_first
      assign prev_e = bcast;
    end else begin : g_mid
      assign prev_e = entry[i-1];
    end

    if (i == N - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_inner
      assign next_e = entry[i+1];
    end

    skl_cell u_cell (
      .clk        (clk),
      .bcast      (bcast),
      .op         (op),
      .valid      (valid[i]),
      .prev_lt    (prev_lt[i]),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .lt         (lt[i]),
      .hit        (hit[i]),
      .entry      (entry[i])
    );
  end

  always_comb begin
    hit_payload = '0;
    for (int i = 0; i < N; i++) begin
      hit_payload = hit_payload | (entry[i].payload & {skl_pkg::PAY_W{hit[i]}});
    end
  end

  always_comb begin
    count_next = count;
    if (op.ins) begin
      count_next = count + skl_pkg::CNT_W'(1);
    end else if (op.rm) begin
      count_next = count - skl_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    res_next.entry_count     = 6'(count_next);
    res_next.removed_payload = '0;
    if (req.req_type == skl_pkg::REQ_INSERT) begin
      res_next.status = full ? skl_pkg::ST_FULL : skl_pkg::ST_DONE;
    end else if (found) begin
      res_next.status          = skl_pkg::ST_DONE;
      res_next.removed_payload = hit_payload;
    end else begin
      res_next.status = skl_pkg::ST_NOT_FOUND;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= skl_pkg::CNT_W'(N))
    else $error("fill count above list depth");

  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit))
    else $error("more than one cell matched the key");

  a_count_idle: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(count))
    else $error("fill count changed without a request");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> (count == $past(count)) ||
               (count == $past(count) + skl_pkg::CNT_W'(1)) ||
               (count == $past(count) - skl_pkg::CNT_W'(1)))
    else $error("fill count moved by more than one");

  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    accept && full && (req.req_type == skl_pkg::REQ_INSERT) |=>
      res.status == skl_pkg::ST_FULL)
    else $error("insert into full list not refused");
`endif

endmodule

// ===== rtl/skl_cell.sv =====
// One list cell: holds an entry, compares it with the broadcast key, shifts either way.
module skl_cell (
  input  logic              clk,
  input  skl_pkg::entry_t   bcast,
  input  skl_pkg::op_t      op,
  input  logic              valid,
  input  logic              prev_lt,
  input  skl_pkg::entry_t   prev_entry,
  input  skl_pkg::entry_t   next_entry,
  output logic              lt,
  output logic              hit,
  output skl_pkg::entry_t   entry
);

  skl_pkg::entry_t entry_next;

  assign lt  = valid && (entry.key < bcast.key);
  assign hit = valid && (entry.key == bcast.key) && prev_lt;

  always_comb begin
    entry_next = entry;
    if (op.ins && !lt) begin
      entry_next = prev_lt ? bcast : prev_entry;
    end else if (op.rm && !lt) begin
      entry_next = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== sim/tb_sorted_key_list.sv =====
// Self-checking testbench for sorted_key_list: directed and random requests against a list predictor.
module tb_sorted_key_list;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STUCK_LIMIT = 2000;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_LEN    = 80;
  localparam int CALM_FROM   = 400;
  localparam int CALM_TO     = 550;
  localparam int IDLE_PCT    = 29;

  typedef struct {
    skl_pkg::req_t body;
    bit            wait_drain;
  } queued_req_t;

  logic          clk;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_stall;
  skl_pkg::req_t req       = '0;
  logic          res_valid;
  logic          res_stall = 1'b0;
  skl_pkg::res_t res;

  queued_req_t   pending_reqs[$];
  skl_pkg::res_t due_results[$];

  logic [skl_pkg::KEY_W-1:0] key_mirror[skl_pkg::LIST_DEPTH];
  logic [skl_pkg::PAY_W-1:0] payload_mirror[skl_pkg::LIST_DEPTH];
  int                        held_count = 0;

  bit req_fired     = 1'b0;
  int requests_taken = 0;
  int results_taken  = 0;
  int stuck_cycles   = 0;
  int error_count    = 0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;

  sorted_key_list uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one request to the mirrored list and returns the result it gives.
  function automatic skl_pkg::res_t apply_list_op(skl_pkg::req_t r);
    skl_pkg::res_t o;
    int            pos;
    int            j;
    bit            hit;
    o = '0;
    o.status = skl_pkg::ST_DONE;
    if (r.req_type == skl_pkg::REQ_INSERT) begin
      if (held_count >= skl_pkg::LIST_DEPTH) begin
        o.status = skl_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && key_mirror[pos] < r.entry_key) pos++;
        for (j = held_count; j > pos; j--) begin
          key_mirror[j]     = key_mirror[j-1];
          payload_mirror[j] = payload_mirror[j-1];
        end
        key_mirror[pos]     = r.entry_key;
        payload_mirror[pos] = r.entry_payload;
        held_count++;
      end
    end else begin
      hit = 1'b0;
      pos = 0;
      for (j = 0; j < held_count && !hit; j++) begin
        if (key_mirror[j] == r.entry_key) begin
          hit = 1'b1;
          pos = j;
        end
      end
      if (!hit) begin
        o.status = skl_pkg::ST_NOT_FOUND;
      end else begin
        o.removed_payload = payload_mirror[pos];
        for (j = pos; j + 1 < held_count; j++) begin
          key_mirror[j]     = key_mirror[j+1];
          payload_mirror[j] = payload_mirror[j+1];
        end
        held_count--;
      end
    end
    o.entry_count = 6'(held_count);
    return o;
  endfunction

  task automatic push_req(logic op, logic [skl_pkg::KEY_W-1:0] k,
                          logic [skl_pkg::PAY_W-1:0] p, bit drain);
    queued_req_t q;
    q.body.req_type      = op;
    q.body.entry_key     = k;
    q.body.entry_payload = p;
    q.wait_drain         = drain;
    pending_reqs.push_back(q);
  endtask

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_valid && !req_fired) begin
      req_valid <= 1'b1;
    end else if (pending_reqs.size() == 0) begin
      req_valid <= 1'b0;
    end else if (pending_reqs[0].wait_drain && due_results.size() != 0) begin
      req_valid <= 1'b0;
    end else if (!(requests_taken >= CALM_FROM && requests_taken < CALM_TO) &&
                 $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= 1'b1;
      req       <= pending_reqs[0].body;
    end
  end

  // result receiver, with one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else if (!hold_done && requests_taken >= HOLD_AT) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_LEN;
      res_stall <= 1'b1;
    end else if (results_taken >= CALM_FROM && results_taken < CALM_TO) begin
      res_stall <= 1'b0;
    end else begin
      res_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // monitor: checks results, then predicts for the request taken at this edge
  always @(posedge clk) begin
    skl_pkg::res_t want;
    bit            req_go;
    bit            res_go;
    req_go = !rst && req_valid && !req_stall;
    res_go = !rst && res_valid && !res_stall;
    req_fired <= req_go;
    if (res_go) begin
      results_taken <= results_taken + 1;
      if (due_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result status %0d count %0d payload %0h",
                 $realtime, res.status, res.entry_count, res.removed_payload);
      end else begin
        want = due_results.pop_front();
        if (res.status !== want.status) begin
          error_count++;
          $display("%0t: status expected %0d actual %0d", $realtime, want.status, res.status);
        end
        if (res.entry_count !== want.entry_count) begin
          error_count++;
          $display("%0t: entry_count expected %0d actual %0d",
                   $realtime, want.entry_count, res.entry_count);
        end
        if (res.removed_payload !== want.removed_payload) begin
          error_count++;
          $display("%0t: removed_payload expected %0h actual %0h",
                   $realtime, want.removed_payload, res.removed_payload);
        end
      end
    end
    if (req_go) begin
      requests_taken <= requests_taken + 1;
      due_results.push_back(apply_list_op(req));
      void'(pending_reqs.pop_front());
    end
    stuck_cycles <= (req_go || res_go) ? 0 : stuck_cycles + 1;
  end

  initial begin
    while (stuck_cycles < STUCK_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  initial begin
    int                        n;
    int                        phase_pos;
    bit                        filling;
    logic                      op;
    logic [skl_pkg::KEY_W-1:0] k;
    // directed: empty list, extremes, equal keys at head and in the middle
    push_req(skl_pkg::REQ_REMOVE, 16'h0000, 16'h1111, 1'b0);
    push_req(skl_pkg::REQ_INSERT, 16'h0000, 16'hFFFF, 1'b0);
    push_req(skl_pkg::REQ_INSERT, 16'hFFFF, 16'h0000, 1'b0);
    push_req(skl_pkg::REQ_INSERT, 16'h0000, 16'h0001, 1'b0);
    push_req(skl_pkg::REQ_INSERT, 16'h8000, 16'hA5A5, 1'b0);
    push_req(skl_pkg::REQ_INSERT, 16'h8000, 16'h5A5A, 1'b0);
    push_req(skl_pkg::REQ_REMOVE, 16'h0000, 16'hFFFF, 1'b0);
    push_req(skl_pkg::REQ_REMOVE, 16'h0000, 16'h0000, 1'b0);
    push_req(skl_pkg::REQ_REMOVE, 16'h1234, 16'hFFFF, 1'b0);
    push_req(skl_pkg::REQ_REMOVE, 16'h8000, 16'h0000, 1'b0);
    push_req(skl_pkg::REQ_REMOVE, 16'hFFFF, 16'h0000, 1'b0);
    push_req(skl_pkg::REQ_REMOVE, 16'h8000, 16'h0000, 1'b0);
    push_req(skl_pkg::REQ_REMOVE, 16'h8000, 16'h0000, 1'b0);
    push_req(skl_pkg::REQ_INSERT, 16'h7FFF, 16'h8000, 1'b0);
    push_req(skl_pkg::REQ_REMOVE, 16'h7FFF, 16'h7FFF, 1'b0);
    // random: alternate fill and empty phases so the list hits full and empty
    filling   = 1'b1;
    phase_pos = 0;
    for (n = 0; n < 735; n++) begin
      if (phase_pos == 70) begin
        phase_pos = 0;
        filling   = !filling;
      end
      if (filling) begin
        op = ($urandom_range(0, 99) < 85) ? skl_pkg::REQ_INSERT : skl_pkg::REQ_REMOVE;
      end else begin
        op = ($urandom_range(0, 99) < 85) ? skl_pkg::REQ_REMOVE : skl_pkg::REQ_INSERT;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: k = 16'($urandom_range(0, 15));
        6:                k = 16'($urandom_range(16'hFFF0, 16'hFFFF));
        default:          k = 16'($urandom_range(0, 16'hFFFF));
      endcase
      push_req(op, k, 16'($urandom_range(0, 16'hFFFF)),
               n == 0 || n == 200 || n == 600);
      phase_pos++;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || due_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
